@@ rtl/core/bmp_pixel_stream_decoder_defines.svh @@
// Assertion macros for the BMP pixel stream decoder checker.
// Each macro expects clk in the scope where it is used; all but BPSD_ASSERT_NXT_RST also expect rst_n.
`ifndef BMP_PIXEL_STREAM_DECODER_DEFINES_SVH
`define BMP_PIXEL_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpsd assertion failed");

// Next-cycle implication, disabled while in reset.
`define BPSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpsd assertion failed");

// Next-cycle implication that also holds across reset.
`define BPSD_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bpsd assertion failed");

`endif

@@ rtl/core/bpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared types and constants of the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpsd_pkg;

  localparam int COORD_W    = 12;
  localparam int HDR_IDX_W  = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Byte positions within the fixed 54-byte header
  localparam logic [HDR_IDX_W-1:0] WIDTH_POS   = 6'd18;
  localparam logic [HDR_IDX_W-1:0] HEIGHT_POS  = 6'd22;
  localparam logic [HDR_IDX_W-1:0] FIELD_BYTES = 6'd4;
  localparam logic [HDR_IDX_W-1:0] HEADER_LAST = 6'd53;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage
`default_nettype wire

@@ rtl/core/bpsd_front.sv @@
// ----------------------------------------------------------------------------
// bpsd_front
// Byte parser: header capture, channel assembly, row and padding tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpsd_front
  import bpsd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_byte_value,
  input  wire logic         in_start_of_file,
  output logic              in_stall,
  input  wire fifo_status_t fifo_st,
  output logic              push,
  output pixel_t            push_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {PH_HEADER, PH_PIXEL, PH_PAD, PH_IDLE} phase_t;

  phase_t                 phase_r, phase_nxt, phase_cur;
  logic [HDR_IDX_W-1:0]   hidx_r, hidx_nxt, hidx_cur;
  logic [31:0]            width_r, width_nxt, width_cur;
  logic [31:0]            height_r, height_nxt, height_cur;
  logic [CW-1:0]          col_r, col_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [1:0]             chan_r, chan_nxt;
  logic [7:0]             blue_r, blue_nxt;
  logic [7:0]             green_r, green_nxt;
  logic [1:0]             pad_r, pad_nxt;
  logic                   accept;
  logic                   col_last;
  logic                   size_ok;
  logic [1:0]             byte_sel;

  assign in_stall = fifo_st.full;
  assign accept   = in_valid & ~in_stall;

  // Start of file acts as a reset folded into this transfer
  assign phase_cur  = in_start_of_file ? PH_HEADER : phase_r;
  assign hidx_cur   = in_start_of_file ? '0 : hidx_r;
  assign width_cur  = in_start_of_file ? '0 : width_r;
  assign height_cur = in_start_of_file ? '0 : height_r;

  assign col_last = ((32'(col_r) + 32'd1) == width_r);
  assign size_ok  = (width_nxt != '0) && (height_nxt != '0) &&
                    (width_nxt <= 32'(MAX_WIDTH)) && (height_nxt <= 32'(MAX_HEIGHT));

  always_comb begin
    phase_nxt  = phase_cur;
    hidx_nxt   = hidx_cur;
    width_nxt  = width_cur;
    height_nxt = height_cur;
    col_nxt    = col_r;
    row_nxt    = row_r;
    chan_nxt   = chan_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    pad_nxt    = pad_r;
    byte_sel   = 2'(hidx_cur - WIDTH_POS);
    push       = 1'b0;

    push_data.red        = in_byte_value;
    push_data.green      = green_r;
    push_data.blue       = blue_r;
    push_data.column     = COORD_W'(col_r);
    push_data.row        = COORD_W'(row_r);
    push_data.last_pixel = (row_r == '0) && col_last;

    case (phase_cur)
      PH_HEADER: begin
        if (hidx_cur >= WIDTH_POS && hidx_cur < WIDTH_POS + FIELD_BYTES) begin
          width_nxt[8*byte_sel +: 8] = in_byte_value;
        end else if (hidx_cur >= HEIGHT_POS && hidx_cur < HEIGHT_POS + FIELD_BYTES) begin
          byte_sel = 2'(hidx_cur - HEIGHT_POS);
          height_nxt[8*byte_sel +: 8] = in_byte_value;
        end
        if (hidx_cur == HEADER_LAST) begin
          hidx_nxt = '0;
          if (size_ok) begin
            phase_nxt = PH_PIXEL;
            row_nxt   = RW'(height_nxt - 32'd1);
            col_nxt   = '0;
            chan_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          hidx_nxt = hidx_cur + 1'b1;
        end
      end
      PH_PIXEL: begin
        case (chan_r)
          2'd0: begin
            blue_nxt = in_byte_value;
            chan_nxt = 2'd1;
          end
          2'd1: begin
            green_nxt = in_byte_value;
            chan_nxt  = 2'd2;
          end
          default: begin
            chan_nxt = 2'd0;
            push     = accept;
            if (col_last) begin
              col_nxt = '0;
              // (4 - 3w mod 4) mod 4 reduces to w mod 4
              pad_nxt = width_r[1:0];
              if (width_r[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end else if (row_r == '0) begin
                phase_nxt = PH_IDLE;
              end else begin
                row_nxt = row_r - 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_nxt = pad_r - 1'b1;
        if (pad_r == 2'd1) begin
          if (row_r == '0) begin
            phase_nxt = PH_IDLE;
          end else begin
            row_nxt   = row_r - 1'b1;
            phase_nxt = PH_PIXEL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      chan_r   <= '0;
      blue_r   <= '0;
      green_r  <= '0;
      pad_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chan_r   <= chan_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      pad_r    <= pad_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bpsd_fifo.sv @@
// ----------------------------------------------------------------------------
// bpsd_fifo
// Short pixel queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpsd_fifo
  import bpsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire pixel_t push_data,
  input  wire logic   pop,
  output pixel_t      rd_data,
  output fifo_status_t st
);

  pixel_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;

  assign st.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign st.empty = (count_r == '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bpsd_back.sv @@
// ----------------------------------------------------------------------------
// bpsd_back
// Output register stage: pops the queue and holds a pixel until transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpsd_back
  import bpsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fifo_status_t fifo_st,
  input  wire pixel_t       rd_data,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output pixel_t            out_pix
);

  logic   valid_r;
  pixel_t pix_r;

  assign pop       = !fifo_st.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_pix   = pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r <= rd_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bmp_pixel_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// 24-bit BMP byte stream to pixel stream decoder.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while in_stall is low. The byte parser
// updates its header, channel and row counters on each transfer, so a byte
// can be transferred on every clock; in_stall rises only when the four-entry
// pixel queue is full, which happens only while out_stall holds the output
// back. A pixel enters the queue on the transfer of its red byte and is then
// registered in the output stage. The first 54 bytes are header; width and
// height outside 1..MAX_WIDTH / 1..MAX_HEIGHT leave the block silent until
// the next in_start_of_file byte, which restarts parsing from header byte 0.
`timescale 1ns / 1ps
`default_nettype none
module bmp_pixel_stream_decoder
  import bpsd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte_value,
  input  wire logic               in_start_of_file,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [COORD_W-1:0]      out_column,
  output logic [COORD_W-1:0]      out_row,
  output logic                    out_last_pixel
);

  fifo_status_t fifo_st;
  logic         push;
  logic         pop;
  pixel_t       push_data;
  pixel_t       rd_data;
  pixel_t       out_pix;

  bpsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte_value    (in_byte_value),
    .in_start_of_file (in_start_of_file),
    .in_stall         (in_stall),
    .fifo_st          (fifo_st),
    .push             (push),
    .push_data        (push_data)
  );

  bpsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .st        (fifo_st)
  );

  bpsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_st   (fifo_st),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  assign out_red        = out_pix.red;
  assign out_green      = out_pix.green;
  assign out_blue       = out_pix.blue;
  assign out_column     = out_pix.column;
  assign out_row        = out_pix.row;
  assign out_last_pixel = out_pix.last_pixel;

endmodule
`default_nettype wire

@@ rtl/core/bpsd_checker.sv @@
// ----------------------------------------------------------------------------
// bpsd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_pixel_stream_decoder_defines.svh"
module bpsd_checker
  import bpsd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [7:0]         out_red,
  input wire logic [7:0]         out_green,
  input wire logic [7:0]         out_blue,
  input wire logic [COORD_W-1:0] out_column,
  input wire logic [COORD_W-1:0] out_row,
  input wire logic               out_last_pixel
);

  // queue and output stage come out of reset empty
  `BPSD_ASSERT_NXT_RST(a_rst_idle, !rst_n, !out_valid && !in_stall)

  // final pixel always sits on the top row
  `BPSD_ASSERT_IMP(a_last_top, out_valid && out_last_pixel, out_row == '0)

  `BPSD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_red) && $stable(out_green) &&
                   $stable(out_blue) && $stable(out_column) && $stable(out_row) &&
                   $stable(out_last_pixel))

  // stall from a full queue only lifts once a pixel leaves
  `BPSD_ASSERT_NXT(a_stall_drain, in_stall && out_stall, in_stall)

endmodule

bind bmp_pixel_stream_decoder bpsd_checker u_bpsd_checker (.*);
`default_nettype wire
